// File: src/gaze_target_lock_qualifier_unit_assert.svh
// Assertion macros shared by the checker of the gaze target lock qualifier.
// No dependencies; included by the checker file only.
`ifndef GAZE_TARGET_LOCK_QUALIFIER_UNIT_ASSERT_SVH
`define GAZE_TARGET_LOCK_QUALIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GTLQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gtlq same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define GTLQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gtlq next-cycle check failed");

`endif

// File: src/gtlq_pkg.sv
// Package of the gaze target lock qualifier: opcodes, register indexes,
// reset values and the structs passed between the modules. No dependencies.
package gtlq_pkg;

   localparam int SPAN_BITS  = 16;
   localparam int NEED_BITS  = 8;
   localparam int LIMIT_BITS = 8;
   localparam int ERROR_BITS = 12;
   localparam int INDEX_BITS = 2;

   localparam logic [SPAN_BITS-1:0]   DIST_SPAN_RESET    = 16'd48;
   localparam logic [NEED_BITS-1:0]   LOCK_NEED_RESET    = 8'd5;
   localparam logic [LIMIT_BITS-1:0]  MOVING_LIMIT_RESET = 8'd5;
   localparam logic [ERROR_BITS-1:0]  ERROR_LIMIT_RESET  = 12'd600;
   localparam logic [ERROR_BITS-1:0]  ERROR_MAX          = '1;

   typedef enum logic [1:0] {
      OP_REGISTER = 2'd0,
      OP_DETECT   = 2'd1,
      OP_CHECK    = 2'd2,
      OP_RESTART  = 2'd3
   } gtlq_op_type;

   typedef enum logic [INDEX_BITS-1:0] {
      CSR_DIST_SPAN    = 2'd0,
      CSR_LOCK_NEED    = 2'd1,
      CSR_MOVING_LIMIT = 2'd2,
      CSR_ERROR_LIMIT  = 2'd3
   } gtlq_csr_type;

   typedef struct packed {
      logic [SPAN_BITS-1:0]   dist_span;
      logic [2*SPAN_BITS-1:0] span_sq;
      logic [NEED_BITS-1:0]   lock_need;
      logic [LIMIT_BITS-1:0]  moving_limit;
      logic [ERROR_BITS-1:0]  error_limit;
   } gtlq_cfg_type;

   typedef struct packed {
      logic accepted;
      logic displaced;
      logic moving;
      logic suspended;
      logic locked;
      logic detect_on;
   } gtlq_flags_type;

endpackage

// File: src/gtlq_cfg.sv
// Configuration registers of the gaze target lock qualifier, including the
// precomputed square of the distance span. Depends on gtlq_pkg.
module gtlq_cfg (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [gtlq_pkg::INDEX_BITS-1:0]    csr_index,
   input  logic [gtlq_pkg::SPAN_BITS-1:0]     csr_wdata,
   output gtlq_pkg::gtlq_cfg_type             cfg
);
   import gtlq_pkg::*;

   logic [SPAN_BITS-1:0]   dist_span_ff, dist_span_in;
   logic [2*SPAN_BITS-1:0] span_sq_ff, span_sq_in;
   logic [NEED_BITS-1:0]   lock_need_ff, lock_need_in;
   logic [LIMIT_BITS-1:0]  moving_limit_ff, moving_limit_in;
   logic [ERROR_BITS-1:0]  error_limit_ff, error_limit_in;
   logic [2*SPAN_BITS-1:0] wdata_sq;

   // The square is taken straight from the write data so that the radius
   // compare downstream needs no multiplier of its own for the span.
   assign wdata_sq = csr_wdata * csr_wdata;

   always_comb begin
      dist_span_in    = dist_span_ff;
      span_sq_in      = span_sq_ff;
      lock_need_in    = lock_need_ff;
      moving_limit_in = moving_limit_ff;
      error_limit_in  = error_limit_ff;
      if (csr_we) begin
         case (gtlq_csr_type'(csr_index))
            CSR_DIST_SPAN: begin
               dist_span_in = csr_wdata;
               span_sq_in   = wdata_sq;
            end
            CSR_LOCK_NEED:    lock_need_in    = csr_wdata[NEED_BITS-1:0];
            CSR_MOVING_LIMIT: moving_limit_in = csr_wdata[LIMIT_BITS-1:0];
            CSR_ERROR_LIMIT:  error_limit_in  = csr_wdata[ERROR_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_span_ff    <= DIST_SPAN_RESET;
         span_sq_ff      <= (2*SPAN_BITS)'(DIST_SPAN_RESET) * (2*SPAN_BITS)'(DIST_SPAN_RESET);
         lock_need_ff    <= LOCK_NEED_RESET;
         moving_limit_ff <= MOVING_LIMIT_RESET;
         error_limit_ff  <= ERROR_LIMIT_RESET;
      end else begin
         dist_span_ff    <= dist_span_in;
         span_sq_ff      <= span_sq_in;
         lock_need_ff    <= lock_need_in;
         moving_limit_ff <= moving_limit_in;
         error_limit_ff  <= error_limit_in;
      end
   end

   assign cfg.dist_span    = dist_span_ff;
   assign cfg.span_sq      = span_sq_ff;
   assign cfg.lock_need    = lock_need_ff;
   assign cfg.moving_limit = moving_limit_ff;
   assign cfg.error_limit  = error_limit_ff;

endmodule

// File: src/gtlq_core.sv
// Tracking state and per-item update logic of the gaze target lock qualifier.
// Produces the offsets and status flags from the updated state. Depends on gtlq_pkg.
module gtlq_core #(
   parameter int COORD_BITS = 16,
   parameter int COUNT_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  gtlq_pkg::gtlq_op_type       op,
   input  logic                        found,
   input  logic [COORD_BITS-1:0]       center_x,
   input  logic [COORD_BITS-1:0]       center_y,
   input  gtlq_pkg::gtlq_cfg_type      cfg,
   output logic signed [COORD_BITS:0]  offset_x,
   output logic signed [COORD_BITS:0]  offset_y,
   output gtlq_pkg::gtlq_flags_type    flags
);
   import gtlq_pkg::*;

   localparam int WIDE_BITS = (COORD_BITS > SPAN_BITS) ? COORD_BITS : SPAN_BITS;
   localparam int CMP_BITS  = (COUNT_BITS > NEED_BITS) ? COUNT_BITS : NEED_BITS;
   localparam logic [COUNT_BITS-1:0] STEADY_MAX = '1;

   logic [COORD_BITS-1:0] target_x_ff, target_x_in, target_y_ff, target_y_in;
   logic [COORD_BITS-1:0] detected_x_ff, detected_x_in, detected_y_ff, detected_y_in;
   logic [COUNT_BITS-1:0] steady_ff, steady_in;
   logic [ERROR_BITS-1:0] error_ff, error_in;
   logic                  locked_ff, locked_in, detect_ff, detect_in;

   logic [COORD_BITS-1:0]  reg_ax, reg_ay, det_ax, det_ay, chk_ax, chk_ay;
   logic [WIDE_BITS-1:0]   span_w;
   logic [WIDE_BITS-1:0]   reg_ax_w, reg_ay_w;
   logic [2*SPAN_BITS-1:0] sq_x, sq_y;
   logic [2*SPAN_BITS:0]   sq_sum;
   logic                   in_radius, near, apart;
   logic [COUNT_BITS-1:0]  steady_inc;
   logic [ERROR_BITS-1:0]  error_inc;
   logic                   accepted, displaced;

   always_comb begin
      reg_ax = (center_x >= target_x_ff) ? center_x - target_x_ff : target_x_ff - center_x;
      reg_ay = (center_y >= target_y_ff) ? center_y - target_y_ff : target_y_ff - center_y;
      det_ax = (center_x >= detected_x_ff) ? center_x - detected_x_ff
                                           : detected_x_ff - center_x;
      det_ay = (center_y >= detected_y_ff) ? center_y - detected_y_ff
                                           : detected_y_ff - center_y;
      chk_ax = (detected_x_ff >= target_x_ff) ? detected_x_ff - target_x_ff
                                              : target_x_ff - detected_x_ff;
      chk_ay = (detected_y_ff >= target_y_ff) ? detected_y_ff - target_y_ff
                                              : target_y_ff - detected_y_ff;
   end

   // Radius test. Squares are only meaningful when both axes are inside the
   // span, and then each distance fits in the span's width.
   assign span_w    = WIDE_BITS'(cfg.dist_span);
   assign reg_ax_w  = WIDE_BITS'(reg_ax);
   assign reg_ay_w  = WIDE_BITS'(reg_ay);
   assign sq_x      = reg_ax_w[SPAN_BITS-1:0] * reg_ax_w[SPAN_BITS-1:0];
   assign sq_y      = reg_ay_w[SPAN_BITS-1:0] * reg_ay_w[SPAN_BITS-1:0];
   assign sq_sum    = {1'b0, sq_x} + {1'b0, sq_y};
   assign in_radius = (reg_ax_w <= span_w) && (reg_ay_w <= span_w)
                      && (sq_sum <= {1'b0, cfg.span_sq});

   assign near  = found && (WIDE_BITS'(det_ax) <= span_w) && (WIDE_BITS'(det_ay) <= span_w);
   assign apart = (WIDE_BITS'(chk_ax) > span_w) || (WIDE_BITS'(chk_ay) > span_w);

   assign steady_inc = (steady_ff == STEADY_MAX) ? steady_ff : steady_ff + 1'b1;
   assign error_inc  = (error_ff == ERROR_MAX) ? error_ff : error_ff + 1'b1;

   always_comb begin
      target_x_in   = target_x_ff;
      target_y_in   = target_y_ff;
      detected_x_in = detected_x_ff;
      detected_y_in = detected_y_ff;
      steady_in     = steady_ff;
      error_in      = error_ff;
      locked_in     = locked_ff;
      detect_in     = detect_ff;
      accepted      = 1'b0;
      displaced     = 1'b0;
      case (op)
         OP_REGISTER: begin
            if (in_radius) begin
               if (CMP_BITS'(steady_inc) > CMP_BITS'(cfg.lock_need)) begin
                  locked_in = 1'b1;
                  steady_in = '0;
                  accepted  = 1'b1;
               end else begin
                  steady_in = steady_inc;
               end
            end else begin
               target_x_in = center_x;
               target_y_in = center_y;
               steady_in   = '0;
               error_in    = error_inc;
            end
         end
         OP_DETECT: begin
            steady_in = near ? steady_inc : '0;
            if (found) begin
               detected_x_in = center_x;
               detected_y_in = center_y;
            end else begin
               error_in = error_inc;
            end
            detect_in = found;
         end
         OP_CHECK: begin
            if (apart) begin
               displaced = 1'b1;
               error_in  = error_inc;
            end else begin
               error_in = '0;
            end
         end
         OP_RESTART: begin
            target_x_in   = '0;
            target_y_in   = '0;
            detected_x_in = '0;
            detected_y_in = '0;
            steady_in     = '0;
            error_in      = '0;
            locked_in     = 1'b0;
            detect_in     = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff   <= '0;
         target_y_ff   <= '0;
         detected_x_ff <= '0;
         detected_y_ff <= '0;
         steady_ff     <= '0;
         error_ff      <= '0;
         locked_ff     <= 1'b0;
         detect_ff     <= 1'b0;
      end else if (step) begin
         target_x_ff   <= target_x_in;
         target_y_ff   <= target_y_in;
         detected_x_ff <= detected_x_in;
         detected_y_ff <= detected_y_in;
         steady_ff     <= steady_in;
         error_ff      <= error_in;
         locked_ff     <= locked_in;
         detect_ff     <= detect_in;
      end
   end

   // Result fields describe the state after this item's update.
   assign offset_x = $signed({1'b0, detected_x_in}) - $signed({1'b0, target_x_in});
   assign offset_y = $signed({1'b0, detected_y_in}) - $signed({1'b0, target_y_in});

   assign flags.accepted  = accepted;
   assign flags.displaced = displaced;
   assign flags.moving    = CMP_BITS'(steady_in) <= CMP_BITS'(cfg.moving_limit);
   assign flags.suspended = error_in > cfg.error_limit;
   assign flags.locked    = locked_in;
   assign flags.detect_on = detect_in;

endmodule

// File: src/gaze_target_lock_qualifier_unit.sv
// Top level of the gaze target lock qualifier: input register, result register
// and handshake control. Depends on gtlq_pkg, gtlq_cfg and gtlq_core.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_ready   opcode, found, center_x, center_y
//   rsp      out        rsp_valid/rsp_ready   accepted, displaced, offsets, flags
//   csr      in         csr_we                csr_index, csr_wdata
//
// One item is taken per clock cycle when the result side keeps up. Its result
// is offered from the result register after the item has passed the input register
// and the state update in gtlq_core, which sets the rate: that update must finish
// for one item before the next can read the tracking state.
// A synchronous, active-high reset clears the tracking state, the stage valid
// flags and the configuration registers to their defaults.
// When the result register is held by a stalled consumer, the input register
// still takes one more item; after that req_ready drops until a result transfer.
module gaze_target_lock_qualifier_unit #(
   parameter int COORD_BITS = 16,
   parameter int COUNT_BITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_opcode,
   input  logic                             req_found,
   input  logic [COORD_BITS-1:0]            req_center_x,
   input  logic [COORD_BITS-1:0]            req_center_y,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_accepted,
   output logic                             rsp_displaced,
   output logic signed [COORD_BITS:0]       rsp_offset_x,
   output logic signed [COORD_BITS:0]       rsp_offset_y,
   output logic                             rsp_moving,
   output logic                             rsp_suspended,
   output logic                             rsp_locked,
   output logic                             rsp_detect_on,
   input  logic                             csr_we,
   input  logic [gtlq_pkg::INDEX_BITS-1:0]  csr_index,
   input  logic [gtlq_pkg::SPAN_BITS-1:0]   csr_wdata
);
   import gtlq_pkg::*;

   gtlq_cfg_type           cfg;
   gtlq_flags_type         flags;
   logic signed [COORD_BITS:0] offset_x, offset_y;

   // Input register.
   logic                  in_valid_ff, in_valid_in;
   gtlq_op_type           op_ff;
   logic                  found_ff;
   logic [COORD_BITS-1:0] cx_ff, cy_ff;

   // Result register.
   logic                       out_valid_ff, out_valid_in;
   gtlq_flags_type             flags_ff;
   logic signed [COORD_BITS:0] offset_x_ff, offset_y_ff;

   logic req_take, out_free, step;

   // The result register can load when it is empty or is being emptied now.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign out_valid_in = step ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff    <= gtlq_op_type'(req_opcode);
         found_ff <= req_found;
         cx_ff    <= req_center_x;
         cy_ff    <= req_center_y;
      end
      if (step) begin
         flags_ff    <= flags;
         offset_x_ff <= offset_x;
         offset_y_ff <= offset_y;
      end
   end

   gtlq_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gtlq_core #(
      .COORD_BITS (COORD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .op       (op_ff),
      .found    (found_ff),
      .center_x (cx_ff),
      .center_y (cy_ff),
      .cfg      (cfg),
      .offset_x (offset_x),
      .offset_y (offset_y),
      .flags    (flags)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_accepted  = flags_ff.accepted;
   assign rsp_displaced = flags_ff.displaced;
   assign rsp_offset_x  = offset_x_ff;
   assign rsp_offset_y  = offset_y_ff;
   assign rsp_moving    = flags_ff.moving;
   assign rsp_suspended = flags_ff.suspended;
   assign rsp_locked    = flags_ff.locked;
   assign rsp_detect_on = flags_ff.detect_on;

endmodule

// File: src/gtlq_checker.sv
// Port-level checks for the gaze target lock qualifier, bound to the top level.
// Depends on gaze_target_lock_qualifier_unit_assert.svh and the top level.
`include "gaze_target_lock_qualifier_unit_assert.svh"

module gtlq_checker #(
   parameter int COORD_BITS = 16
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_accepted,
   input logic                       rsp_displaced,
   input logic signed [COORD_BITS:0] rsp_offset_x,
   input logic signed [COORD_BITS:0] rsp_offset_y,
   input logic                       rsp_moving,
   input logic                       rsp_locked
);

   // A stalled result keeps its valid, its offsets and its accepted flag.
   `GTLQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_offset_x) && $stable(rsp_offset_y) && $stable(rsp_accepted))

   // A lock is reported together with the locked flag.
   `GTLQ_ASSERT_NOW(a_accept_locked, clock, reset, rsp_valid && rsp_accepted, rsp_locked)

   // A lock clears the steady count, so the target always reads as moving.
   `GTLQ_ASSERT_NOW(a_accept_moving, clock, reset, rsp_valid && rsp_accepted, rsp_moving)

   // Register and check operations are exclusive in one result.
   `GTLQ_ASSERT_NOW(a_flag_exclusive, clock, reset, rsp_valid, !(rsp_accepted && rsp_displaced))

endmodule

bind gaze_target_lock_qualifier_unit gtlq_checker #(
   .COORD_BITS (COORD_BITS)
) u_gtlq_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_accepted  (rsp_accepted),
   .rsp_displaced (rsp_displaced),
   .rsp_offset_x  (rsp_offset_x),
   .rsp_offset_y  (rsp_offset_y),
   .rsp_moving    (rsp_moving),
   .rsp_locked    (rsp_locked)
);

// File: tb/tb_gaze_target_lock_qualifier_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for gaze_target_lock_qualifier_unit: directed table, random
// phases and a counter saturation run, scored against an in-bench tracking predictor
// or a typed-in result. Depends on gtlq_pkg and the block's RTL only.
module tb_gaze_target_lock_qualifier_unit;
   import gtlq_pkg::*;

   localparam int COORD_W = 16;
   localparam int COUNT_W = 8;
   localparam logic [COUNT_W-1:0] STEADY_TOP = '1;
   // Far above the slowest legal run: about 500 transfers, each waiting out
   // the longest sender gap and the longest result stall.
   localparam int RUN_LIMIT_NS = 3_000_000;

   // One result transfer, field by field.
   typedef struct {
      logic                      accepted;
      logic                      displaced;
      logic signed [COORD_W:0]   offset_x;
      logic signed [COORD_W:0]   offset_y;
      logic                      moving;
      logic                      suspended;
      logic                      locked;
      logic                      detect_on;
   } gaze_result_type;

   // One input transfer; when known is set the expected result is typed in
   // by hand rather than taken from the predictor.
   typedef struct {
      gtlq_op_type         op;
      logic                found;
      logic [COORD_W-1:0]  cx;
      logic [COORD_W-1:0]  cy;
      bit                  known;
      gaze_result_type     want;
   } sample_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_opcode = OP_CHECK;
   logic                      req_found = 1'b0;
   logic [COORD_W-1:0]        req_center_x = '0;
   logic [COORD_W-1:0]        req_center_y = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_accepted;
   logic                      rsp_displaced;
   logic signed [COORD_W:0]   rsp_offset_x;
   logic signed [COORD_W:0]   rsp_offset_y;
   logic                      rsp_moving;
   logic                      rsp_suspended;
   logic                      rsp_locked;
   logic                      rsp_detect_on;
   logic                      csr_we = 1'b0;
   logic [INDEX_BITS-1:0]     csr_index = CSR_DIST_SPAN;
   logic [SPAN_BITS-1:0]      csr_wdata = '0;

   // Predictor copy of the configuration registers, at their reset values.
   logic [SPAN_BITS-1:0]      cfg_span     = DIST_SPAN_RESET;
   logic [NEED_BITS-1:0]      cfg_need     = LOCK_NEED_RESET;
   logic [LIMIT_BITS-1:0]     cfg_move_lim = MOVING_LIMIT_RESET;
   logic [ERROR_BITS-1:0]     cfg_err_lim  = ERROR_LIMIT_RESET;

   // Predictor copy of the tracking state.
   logic [COORD_W-1:0]        trk_tgt_x = '0;
   logic [COORD_W-1:0]        trk_tgt_y = '0;
   logic [COORD_W-1:0]        trk_det_x = '0;
   logic [COORD_W-1:0]        trk_det_y = '0;
   logic [COUNT_W-1:0]        trk_steady = '0;
   logic [ERROR_BITS-1:0]     trk_errors = '0;
   logic                      trk_locked = 1'b0;
   logic                      trk_detect = 1'b0;

   gaze_result_type           pending_results[$];
   int                        mismatches = 0;
   int                        results_seen = 0;
   bit                        idle_on = 1'b1;
   logic [COORD_W-1:0]        anchor_x = 16'h4000;
   logic [COORD_W-1:0]        anchor_y = 16'h3000;

   gaze_target_lock_qualifier_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_found     (req_found),
      .req_center_x  (req_center_x),
      .req_center_y  (req_center_y),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_accepted  (rsp_accepted),
      .rsp_displaced (rsp_displaced),
      .rsp_offset_x  (rsp_offset_x),
      .rsp_offset_y  (rsp_offset_y),
      .rsp_moving    (rsp_moving),
      .rsp_suspended (rsp_suspended),
      .rsp_locked    (rsp_locked),
      .rsp_detect_on (rsp_detect_on),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic longint unsigned axis_gap(logic [COORD_W-1:0] a,
                                                logic [COORD_W-1:0] b);
      return (a >= b) ? longint'(a - b) : longint'(b - a);
   endfunction

   // The error counter sticks at its top value instead of wrapping.
   function automatic void count_error();
      if (trk_errors != ERROR_MAX) begin
         trk_errors = trk_errors + 1'b1;
      end
   endfunction

   // Applies one sample to the tracking state and returns the result that the
   // block must give for it; all status flags are taken after the update.
   function automatic gaze_result_type track_sample(gtlq_op_type op, logic found,
                                                    logic [COORD_W-1:0] cx,
                                                    logic [COORD_W-1:0] cy);
      gaze_result_type r;
      longint unsigned ax, ay, span;
      span = longint'(cfg_span);
      r.accepted = 1'b0;
      r.displaced = 1'b0;
      case (op)
         OP_REGISTER: begin
            // Radius test on squared values, exact in 64 bits.
            ax = axis_gap(cx, trk_tgt_x);
            ay = axis_gap(cy, trk_tgt_y);
            if (ax <= span && ay <= span && ax * ax + ay * ay <= span * span) begin
               if (trk_steady != STEADY_TOP) begin
                  trk_steady = trk_steady + 1'b1;
               end
               if (trk_steady > cfg_need) begin
                  trk_locked = 1'b1;
                  trk_steady = '0;
                  r.accepted = 1'b1;
               end
            end else begin
               trk_tgt_x = cx;
               trk_tgt_y = cy;
               trk_steady = '0;
               count_error();
            end
         end
         OP_DETECT: begin
            // Per-axis box test against the previous detected centre.
            if (found && axis_gap(cx, trk_det_x) <= span
                && axis_gap(cy, trk_det_y) <= span) begin
               if (trk_steady != STEADY_TOP) begin
                  trk_steady = trk_steady + 1'b1;
               end
            end else begin
               trk_steady = '0;
            end
            if (found) begin
               trk_det_x = cx;
               trk_det_y = cy;
            end else begin
               count_error();
            end
            trk_detect = found;
         end
         OP_CHECK: begin
            if (axis_gap(trk_det_x, trk_tgt_x) > span
                || axis_gap(trk_det_y, trk_tgt_y) > span) begin
               r.displaced = 1'b1;
               count_error();
            end else begin
               trk_errors = '0;
            end
         end
         default: begin
            // Restart clears the tracking state but keeps the registers.
            trk_tgt_x = '0;
            trk_tgt_y = '0;
            trk_det_x = '0;
            trk_det_y = '0;
            trk_steady = '0;
            trk_errors = '0;
            trk_locked = 1'b0;
            trk_detect = 1'b0;
         end
      endcase
      r.offset_x = {1'b0, trk_det_x} - {1'b0, trk_tgt_x};
      r.offset_y = {1'b0, trk_det_y} - {1'b0, trk_tgt_y};
      r.moving = (trk_steady <= cfg_move_lim);
      r.suspended = (trk_errors > cfg_err_lim);
      r.locked = trk_locked;
      r.detect_on = trk_detect;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic sample_type mk_sample(gtlq_op_type op, logic found,
                                            logic [COORD_W-1:0] cx,
                                            logic [COORD_W-1:0] cy);
      sample_type s;
      s.op = op;
      s.found = found;
      s.cx = cx;
      s.cy = cy;
      s.known = 1'b0;
      return s;
   endfunction

   function automatic sample_type mk_known(gtlq_op_type op, logic found,
                                           logic [COORD_W-1:0] cx,
                                           logic [COORD_W-1:0] cy,
                                           gaze_result_type want);
      sample_type s;
      s = mk_sample(op, found, cx, cy);
      s.known = 1'b1;
      s.want = want;
      return s;
   endfunction

   // Mostly short pauses, now and then a long one.
   function automatic int pause_len();
      if ($urandom_range(0, 99) < 80) begin
         return $urandom_range(0, 2);
      end
      return $urandom_range(3, 24);
   endfunction

   // Random samples are mostly jittered around an anchor that now and then jumps, so that
   // steady runs, locks and detections happen; the rest is full-range noise.
   function automatic sample_type random_sample();
      int pick;
      int amp;
      gtlq_op_type op;
      logic [COORD_W-1:0] cx, cy;
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
         op = OP_REGISTER;
      end else if (pick < 77) begin
         op = OP_DETECT;
      end else if (pick < 95) begin
         op = OP_CHECK;
      end else begin
         op = OP_RESTART;
      end
      if ($urandom_range(0, 19) == 0) begin
         case ($urandom_range(0, 3))
            0: begin
               anchor_x = '0;
               anchor_y = '1;
            end
            1: begin
               anchor_x = '1;
               anchor_y = '0;
            end
            default: begin
               anchor_x = 16'($urandom);
               anchor_y = 16'($urandom);
            end
         endcase
      end
      amp = (cfg_span < 100) ? int'(cfg_span) + 2 : 100;
      if ($urandom_range(0, 4) == 0) begin
         cx = 16'($urandom);
         cy = 16'($urandom);
      end else if ($urandom_range(0, 9) < 4) begin
         cx = anchor_x;
         cy = anchor_y;
      end else begin
         cx = anchor_x + 16'($urandom_range(0, 2 * amp) - amp);
         cy = anchor_y + 16'($urandom_range(0, 2 * amp) - amp);
      end
      return mk_sample(op, ($urandom_range(0, 9) != 0), cx, cy);
   endfunction

   // Presents one sample and waits for its transfer; the prediction is made at
   // the transfer so that it sees the state left by every earlier sample.
   task automatic send(sample_type s);
      gaze_result_type pred;
      req_valid <= 1'b1;
      req_opcode <= s.op;
      req_found <= s.found;
      req_center_x <= s.cx;
      req_center_y <= s.cy;
      do @(posedge clock); while (!req_ready);
      pred = track_sample(s.op, s.found, s.cx, s.cy);
      pending_results.push_back(s.known ? s.want : pred);
   endtask

   task automatic pause_sender();
      int n;
      n = (idle_on && $urandom_range(0, 1) == 1) ? pause_len() : 0;
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Drains the block: every result home, then a wait for the two stages.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(gtlq_csr_type idx, logic [SPAN_BITS-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_DIST_SPAN:    cfg_span = data;
         CSR_LOCK_NEED:    cfg_need = data[NEED_BITS-1:0];
         CSR_MOVING_LIMIT: cfg_move_lim = data[LIMIT_BITS-1:0];
         default:          cfg_err_lim = data[ERROR_BITS-1:0];
      endcase
   endtask

   // Writes all four registers; bits above a narrow register are filled with
   // noise, which the block must drop.
   task automatic configure(logic [SPAN_BITS-1:0] span, logic [NEED_BITS-1:0] need,
                            logic [LIMIT_BITS-1:0] move_lim, logic [ERROR_BITS-1:0] err_lim);
      write_reg(CSR_DIST_SPAN, span);
      write_reg(CSR_LOCK_NEED, {8'($urandom), need});
      write_reg(CSR_MOVING_LIMIT, {8'($urandom), move_lim});
      write_reg(CSR_ERROR_LIMIT, {4'($urandom), err_lim});
      csr_we <= 1'b0;
   endtask

   task automatic run_random(int count, bit calm);
      idle_on <= !calm;
      repeat (count) begin
         send(random_sample());
         pause_sender();
      end
   endtask

   // ------------------------------------------------------------------
   // Result side: random stalls, checking against the oldest expectation
   // ------------------------------------------------------------------

   task automatic report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                   results_seen, name, got, want));
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!idle_on || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            repeat (pause_len()) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      gaze_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
         end else begin
            want = pending_results.pop_front();
            check_field("accepted", rsp_accepted, want.accepted);
            check_field("displaced", rsp_displaced, want.displaced);
            check_field("offset_x", rsp_offset_x, want.offset_x);
            check_field("offset_y", rsp_offset_y, want.offset_y);
            check_field("moving", rsp_moving, want.moving);
            check_field("suspended", rsp_suspended, want.suspended);
            check_field("locked", rsp_locked, want.locked);
            check_field("detect_on", rsp_detect_on, want.detect_on);
         end
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------

   initial begin
      sample_type script[$];
      logic [SPAN_BITS-1:0] span;
      logic [COORD_W-1:0] px, py;

      // Directed table, run with the reset configuration (span 3.0 pixels,
      // lock after more than five steady samples). Rows with a typed result are
      // the ones whose outcome is plain from the cleared or extreme state.
      script.push_back(mk_known(OP_CHECK, 1'b0, 16'h0000, 16'h0000,
                                '{1'b0, 1'b0, 17'sd0, 17'sd0, 1'b1, 1'b0, 1'b0, 1'b0}));
      script.push_back(mk_sample(OP_REGISTER, 1'b1, 16'h0000, 16'h0000));
      // A sample at the far corner is out of span, so the target jumps there and
      // the offset reaches its most negative value.
      script.push_back(mk_known(OP_REGISTER, 1'b0, 16'hFFFF, 16'hFFFF,
                                '{1'b0, 1'b0, -17'sd65535, -17'sd65535, 1'b1, 1'b0, 1'b0, 1'b0}));
      // Six steady samples on the target: the sixth exceeds the need and locks.
      repeat (6) script.push_back(mk_sample(OP_REGISTER, 1'b0, 16'hFFFF, 16'hFFFF));
      // Exactly on the radius along one axis is still inside.
      script.push_back(mk_sample(OP_REGISTER, 1'b1, 16'hFFCF, 16'hFFFF));
      // Within the box on both axes but outside the circle.
      script.push_back(mk_sample(OP_REGISTER, 1'b0, 16'hFFDD, 16'hFFDD));
      script.push_back(mk_sample(OP_DETECT, 1'b1, 16'hFFFF, 16'h0000));
      // Moved by exactly the span on both axes: counts as steady for detect.
      script.push_back(mk_sample(OP_DETECT, 1'b1, 16'hFFCF, 16'h0030));
      // No centre found: coordinates ignored, error counted, detection off.
      script.push_back(mk_sample(OP_DETECT, 1'b0, 16'h1234, 16'h5678));
      script.push_back(mk_sample(OP_CHECK, 1'b1, 16'hFFFF, 16'hFFFF));
      script.push_back(mk_sample(OP_DETECT, 1'b1, 16'hFFDD, 16'hFFDD));
      // Detected centre on the target: the check clears the error count.
      script.push_back(mk_sample(OP_CHECK, 1'b0, 16'h0000, 16'h0000));
      script.push_back(mk_known(OP_RESTART, 1'b1, 16'hFFFF, 16'hFFFF,
                                '{1'b0, 1'b0, 17'sd0, 17'sd0, 1'b1, 1'b0, 1'b0, 1'b0}));
      script.push_back(mk_sample(OP_DETECT, 1'b1, 16'h0000, 16'h0000));
      script.push_back(mk_sample(OP_REGISTER, 1'b0, 16'h0030, 16'h0000));
      script.push_back(mk_sample(OP_CHECK, 1'b1, 16'hFFFF, 16'h0000));
      script.push_back(mk_known(OP_RESTART, 1'b0, 16'h0000, 16'h0000,
                                '{1'b0, 1'b0, 17'sd0, 17'sd0, 1'b1, 1'b0, 1'b0, 1'b0}));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         send(script[i]);
         pause_sender();
      end
      settle();

      // Random phases over several settings, the extremes first. Calm phases
      // run without any idling on either side.
      configure(16'd0, 8'd0, 8'd0, 12'd0);
      run_random(30, 1'b0);
      settle();
      configure(16'hFFFF, 8'hFF, 8'hFF, 12'hFFF);
      run_random(30, 1'b1);
      settle();
      configure(DIST_SPAN_RESET, LOCK_NEED_RESET, MOVING_LIMIT_RESET, ERROR_LIMIT_RESET);
      run_random(30, 1'b0);
      settle();
      repeat (4) begin
         configure(16'($urandom_range(0, 200)), 8'($urandom_range(0, 10)),
                   8'($urandom_range(0, 10)), 12'($urandom_range(0, 20)));
         run_random(30, 1'($urandom_range(0, 1)));
         settle();
      end

      // Steady counter saturation through detect at the origin with a lock need
      // of 255: the count climbs past the moving limit to its top value and holds
      // there, and register samples on the cleared target then cannot lock.
      span = 16'($urandom_range(0, 64));
      px = 16'($urandom);
      py = 16'($urandom);
      idle_on <= 1'b0;
      configure(span, 8'd255, 8'd254, 12'd600);
      send(mk_sample(OP_RESTART, 1'b0, px, py));
      repeat (260) send(mk_sample(OP_DETECT, 1'b1, 16'h0000, 16'h0000));
      repeat (4) send(mk_sample(OP_REGISTER, 1'($urandom), 16'h0000, 16'h0000));
      settle();
      configure(span, 8'd255, 8'd255, 12'd600);
      send(mk_sample(OP_DETECT, 1'b1, 16'h0000, 16'h0000));
      settle();

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/gtlq_pkg.sv
src/gtlq_cfg.sv
src/gtlq_core.sv
src/gaze_target_lock_qualifier_unit.sv
src/gtlq_checker.sv
tb/tb_gaze_target_lock_qualifier_unit.sv
